### hdl/delimited_token_stream_extractor_defines.svh
// Assertion macros used by the checker file.
`ifndef DELIMITED_TOKEN_STREAM_EXTRACTOR_DEFINES_SVH
`define DELIMITED_TOKEN_STREAM_EXTRACTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTSE_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dtse check failed");

// The consequent must hold in the cycle after the antecedent.
`define DTSE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dtse check failed");

`endif

### hdl/dtse_pkg.sv
package dtse_pkg;

    localparam int PREFIX_MAX   = 32;
    localparam int SUFFIX_MAX   = 16;
    localparam int KEY_LEN      = 172;
    localparam int OFFSET_WIDTH = 32;

    localparam int PREFIX_LIM  = (PREFIX_MAX < 32) ? PREFIX_MAX : 32;
    localparam int SUFFIX_LIM  = (SUFFIX_MAX < 16) ? SUFFIX_MAX : 16;
    localparam int WIN_DEPTH   = (PREFIX_LIM > SUFFIX_LIM + 1) ? PREFIX_LIM : SUFFIX_LIM + 1;
    localparam int PFLAG_DEPTH = KEY_LEN + SUFFIX_LIM;
    localparam int KEY_WORDS   = (KEY_LEN + 7) / 8;
    localparam int LAST_BYTES  = KEY_LEN - 8 * (KEY_WORDS - 1);
    localparam int WCNT_W      = $clog2(KEY_WORDS + 1);
    localparam int TOT_W       = $clog2(PREFIX_LIM + KEY_LEN + SUFFIX_LIM + 1);
    localparam int RUN_W       = 9;
    localparam int RUN_MAX     = 511;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PREFIX_WORD0  = 3'd0;
    localparam cfg_idx_t REG_PREFIX_WORD1  = 3'd1;
    localparam cfg_idx_t REG_PREFIX_WORD2  = 3'd2;
    localparam cfg_idx_t REG_PREFIX_WORD3  = 3'd3;
    localparam cfg_idx_t REG_SUFFIX_WORD0  = 3'd4;
    localparam cfg_idx_t REG_SUFFIX_WORD1  = 3'd5;
    localparam cfg_idx_t REG_PREFIX_LENGTH = 3'd6;
    localparam cfg_idx_t REG_SUFFIX_LENGTH = 3'd7;

    localparam logic STATUS_KEY       = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_EQUAL = 8'h3D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_t;

    typedef struct packed {
        logic        status;
        logic [63:0] key_word;
        logic [3:0]  word_bytes;
        logic [31:0] key_offset;
        logic        last_word;
    } out_t;

    function automatic logic is_key_class(input logic [7:0] b);
        return ((b >= CHAR_A) && (b <= CHAR_LOW_Z)) || (b == CHAR_DASH) ||
               (b == CHAR_EQUAL) || ((b >= CHAR_0) && (b <= CHAR_9));
    endfunction

endpackage

### hdl/delimited_token_stream_extractor.sv
// Searches a byte stream for the first place where the configured prefix is followed by
// exactly KEY_LEN key-class bytes and then the configured suffix, and returns that key as
// a burst of 8-byte words tagged with the stream offset of its first byte; a stream that
// ends without a match returns one not-found word. One byte is taken per clock cycle while
// the input is not held; a byte is accepted into an input register and compared against
// the prefix and suffix there, so the first key word reaches the output register after the
// burst flag is set, and a not-found word as the final byte is taken. A key burst holds
// KEY_WORDS words (22 with a 172-byte key), one word per cycle while the output is not
// held, set by the key line shift-out; later bytes of the same stream keep flowing during
// the burst, while the next stream's first byte waits until it is out. Configuration is
// written via the cfg port by the user only while no stream is in flight (not enforced).
module delimited_token_stream_extractor (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  dtse_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output dtse_pkg::out_t                   m_data,
    input  logic                             cfg_wr_en,
    input  dtse_pkg::cfg_idx_t               cfg_index,
    input  logic [dtse_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [3:0][63:0] prefix_word_reg;
    logic [1:0][63:0] suffix_word_reg;
    logic [5:0]       prefix_length_reg;
    logic [4:0]       suffix_length_reg;

    logic [31:0][7:0] prefix_bytes;
    logic [15:0][7:0] suffix_bytes;
    logic [5:0]       plen;
    logic [4:0]       slen;

    logic             in_valid_reg;
    dtse_pkg::in_t    in_reg;

    logic [7:0]                       win_reg  [dtse_pkg::WIN_DEPTH-1];
    logic [7:0]                       win_next [dtse_pkg::WIN_DEPTH];
    logic [7:0]                       key_reg  [dtse_pkg::KEY_LEN];
    logic [dtse_pkg::PFLAG_DEPTH-1:0] pf_reg;
    logic [dtse_pkg::SUFFIX_LIM:0]    pf_tap;
    logic [dtse_pkg::RUN_W-1:0]       run_reg  [dtse_pkg::SUFFIX_LIM];
    logic [dtse_pkg::RUN_W-1:0]       run_next [dtse_pkg::SUFFIX_LIM+1];
    logic [dtse_pkg::OFFSET_WIDTH-1:0] seen_reg;
    logic [dtse_pkg::OFFSET_WIDTH-1:0] seen_next;
    logic [dtse_pkg::OFFSET_WIDTH-1:0] off_reg;
    logic [dtse_pkg::OFFSET_WIDTH-1:0] off_next;
    logic [dtse_pkg::TOT_W-1:0]        total;
    logic                              found_reg;

    logic pref_ok;
    logic suf_ok;
    logic run_ok;
    logic seen_ok;
    logic match_now;
    logic nf_now;
    logic can_take;
    logic take;
    logic shift_in;
    logic out_free;

    logic                       burst_reg;
    logic [dtse_pkg::WCNT_W-1:0] wcnt_reg;
    logic                       burst_step;
    logic [3:0]                 nb;
    logic [63:0]                burst_word;

    logic           m_valid_reg;
    dtse_pkg::out_t m_data_reg;
    dtse_pkg::out_t m_data_next;

    assign prefix_bytes = prefix_word_reg;
    assign suffix_bytes = suffix_word_reg;
    assign plen = (prefix_length_reg > 6'(dtse_pkg::PREFIX_LIM)) ?
                  6'(dtse_pkg::PREFIX_LIM) : prefix_length_reg;
    assign slen = (suffix_length_reg > 5'(dtse_pkg::SUFFIX_LIM)) ?
                  5'(dtse_pkg::SUFFIX_LIM) : suffix_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_word_reg   <= '0;
            suffix_word_reg   <= '0;
            prefix_length_reg <= '0;
            suffix_length_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dtse_pkg::REG_PREFIX_WORD0:  prefix_word_reg[0] <= cfg_data;
                dtse_pkg::REG_PREFIX_WORD1:  prefix_word_reg[1] <= cfg_data;
                dtse_pkg::REG_PREFIX_WORD2:  prefix_word_reg[2] <= cfg_data;
                dtse_pkg::REG_PREFIX_WORD3:  prefix_word_reg[3] <= cfg_data;
                dtse_pkg::REG_SUFFIX_WORD0:  suffix_word_reg[0] <= cfg_data;
                dtse_pkg::REG_SUFFIX_WORD1:  suffix_word_reg[1] <= cfg_data;
                dtse_pkg::REG_PREFIX_LENGTH: prefix_length_reg <= cfg_data[5:0];
                dtse_pkg::REG_SUFFIX_LENGTH: suffix_length_reg <= cfg_data[4:0];
            endcase
        end
    end

    always_comb begin
        win_next[0] = in_reg.data_byte;
        for (int i = 1; i < dtse_pkg::WIN_DEPTH; i++) begin
            win_next[i] = win_reg[i-1];
        end
    end

    always_comb begin
        if (!dtse_pkg::is_key_class(in_reg.data_byte)) begin
            run_next[0] = '0;
        end else if (run_reg[0] == dtse_pkg::RUN_W'(dtse_pkg::RUN_MAX)) begin
            run_next[0] = run_reg[0];
        end else begin
            run_next[0] = run_reg[0] + 1'b1;
        end
        for (int i = 1; i <= dtse_pkg::SUFFIX_LIM; i++) begin
            run_next[i] = run_reg[i-1];
        end
    end

    always_comb begin
        logic [5:0] pidx;
        pref_ok = 1'b1;
        for (int i = 0; i < dtse_pkg::PREFIX_LIM; i++) begin
            pidx = plen - 6'(i) - 6'd1;
            if ((6'(i) < plen) && (win_next[i] != prefix_bytes[pidx[4:0]])) begin
                pref_ok = 1'b0;
            end
        end
    end

    always_comb begin
        logic [4:0] sidx;
        suf_ok = 1'b1;
        for (int i = 0; i < dtse_pkg::SUFFIX_LIM; i++) begin
            sidx = slen - 5'(i) - 5'd1;
            if ((5'(i) < slen) && (win_next[i] != suffix_bytes[sidx[3:0]])) begin
                suf_ok = 1'b0;
            end
        end
    end

    always_comb begin
        for (int s = 0; s <= dtse_pkg::SUFFIX_LIM; s++) begin
            pf_tap[s] = pf_reg[dtse_pkg::KEY_LEN - 1 + s];
        end
    end

    assign seen_next = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;
    assign total     = dtse_pkg::TOT_W'(plen) + dtse_pkg::TOT_W'(dtse_pkg::KEY_LEN)
                     + dtse_pkg::TOT_W'(slen);
    assign seen_ok   = seen_next >= dtse_pkg::OFFSET_WIDTH'(total);
    assign run_ok    = run_next[slen] >= dtse_pkg::RUN_W'(dtse_pkg::KEY_LEN);
    assign off_next  = seen_next - dtse_pkg::OFFSET_WIDTH'(slen)
                     - dtse_pkg::OFFSET_WIDTH'(dtse_pkg::KEY_LEN);

    assign match_now  = !found_reg && seen_ok && suf_ok && run_ok && pf_tap[slen];
    assign nf_now     = in_reg.end_of_stream && !found_reg && !match_now;
    assign out_free   = !m_valid_reg || m_ready;
    assign can_take   = found_reg || (!burst_reg && (!nf_now || out_free));
    assign take       = in_valid_reg && can_take;
    assign shift_in   = take && !found_reg;
    assign burst_step = burst_reg && out_free;
    assign s_ready    = !in_valid_reg || can_take;

    assign nb = (wcnt_reg == dtse_pkg::WCNT_W'(1)) ? 4'(dtse_pkg::LAST_BYTES) : 4'd8;

    for (genvar k = 0; k < 8; k++) begin : g_word
        if (k < dtse_pkg::KEY_LEN) begin : g_byte
            assign burst_word[8*k +: 8] = (4'(k) < nb) ? key_reg[dtse_pkg::KEY_LEN-1-k] : 8'h00;
        end else begin : g_pad
            assign burst_word[8*k +: 8] = 8'h00;
        end
    end

    always_comb begin
        if (burst_step) begin
            m_data_next.status     = dtse_pkg::STATUS_KEY;
            m_data_next.key_word   = burst_word;
            m_data_next.word_bytes = nb;
            m_data_next.key_offset = 32'(off_reg);
            m_data_next.last_word  = (wcnt_reg == dtse_pkg::WCNT_W'(1));
        end else begin
            m_data_next.status     = dtse_pkg::STATUS_NOT_FOUND;
            m_data_next.key_word   = '0;
            m_data_next.word_bytes = '0;
            m_data_next.key_offset = '0;
            m_data_next.last_word  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            seen_reg     <= '0;
            burst_reg    <= 1'b0;
            wcnt_reg     <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < dtse_pkg::SUFFIX_LIM; i++) begin
                run_reg[i] <= '0;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (take) begin
                if (in_reg.end_of_stream) begin
                    found_reg <= 1'b0;
                    seen_reg  <= '0;
                end else if (!found_reg) begin
                    found_reg <= match_now;
                    seen_reg  <= seen_next;
                end
            end
            if (shift_in) begin
                for (int i = 1; i < dtse_pkg::SUFFIX_LIM; i++) begin
                    run_reg[i] <= run_next[i];
                end
                run_reg[0] <= in_reg.end_of_stream ? '0 : run_next[0];
            end else if (take && in_reg.end_of_stream) begin
                run_reg[0] <= '0;
            end
            if (shift_in && match_now) begin
                burst_reg <= 1'b1;
                wcnt_reg  <= dtse_pkg::WCNT_W'(dtse_pkg::KEY_WORDS);
            end else if (burst_step) begin
                wcnt_reg <= wcnt_reg - 1'b1;
                if (wcnt_reg == dtse_pkg::WCNT_W'(1)) begin
                    burst_reg <= 1'b0;
                end
            end
            if (out_free) begin
                m_valid_reg <= burst_step || (take && nf_now);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (shift_in) begin
            for (int i = 0; i < dtse_pkg::WIN_DEPTH - 1; i++) begin
                win_reg[i] <= win_next[i];
            end
            pf_reg <= {pf_reg[dtse_pkg::PFLAG_DEPTH-2:0], pref_ok};
            key_reg[0] <= win_next[slen];
            for (int i = 1; i < dtse_pkg::KEY_LEN; i++) begin
                key_reg[i] <= key_reg[i-1];
            end
        end else if (burst_step) begin
            for (int i = 8; i < dtse_pkg::KEY_LEN; i++) begin
                key_reg[i] <= key_reg[i-8];
            end
        end
        if (shift_in && match_now) begin
            off_reg <= off_next;
        end
        if (out_free && (burst_step || (take && nf_now))) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/dtse_checker.sv
`include "delimited_token_stream_extractor_defines.svh"

module dtse_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input dtse_pkg::out_t m_data
);

    logic nf_word;
    logic nf_fields_zero;
    logic key_word_out;
    logic key_mid_word;
    logic key_mid_taken;

    assign nf_word        = m_valid && (m_data.status == dtse_pkg::STATUS_NOT_FOUND);
    assign nf_fields_zero = m_data.last_word && (m_data.word_bytes == 4'd0) &&
                            (m_data.key_offset == 32'd0);
    assign key_word_out   = m_valid && (m_data.status == dtse_pkg::STATUS_KEY);
    assign key_mid_word   = key_word_out && !m_data.last_word;
    assign key_mid_taken  = key_mid_word && m_ready;

    `DTSE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    `DTSE_ASSERT_NOW(a_not_found_word, nf_word, nf_fields_zero)

    `DTSE_ASSERT_NOW(a_full_word, key_mid_word, m_data.word_bytes == 4'd8)

    `DTSE_ASSERT_NEXT(a_burst_gapless, key_mid_taken, key_word_out && $stable(m_data.key_offset))

endmodule

bind delimited_token_stream_extractor dtse_checker u_dtse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
